// ----- src/mseu_pkg.sv -----
// Shared types, opcodes and sizes for the MIPS subset execute unit.
package mseu_pkg;

    // Data memory size in words and the address width that follows from it.
    localparam int DATA_WORDS = 1024;
    localparam int ADDR_W     = $clog2(DATA_WORDS);

    // Limits for the range checks on word offsets and word indexes.
    localparam logic [29:0] WORD_LIMIT = 30'(DATA_WORDS);
    localparam logic [16:0] WIDX_LIMIT = 17'(DATA_WORDS);

    typedef logic [ADDR_W-1:0] addr_t;

    // Input word kinds.
    localparam logic [1:0] KIND_EXEC    = 2'd0;
    localparam logic [1:0] KIND_PRELOAD = 2'd1;
    localparam logic [1:0] KIND_READ    = 2'd2;

    // Primary opcodes.
    localparam logic [5:0] OP_SPECIAL = 6'h00;
    localparam logic [5:0] OP_ADDIU   = 6'h09;
    localparam logic [5:0] OP_SLTIU   = 6'h0B;
    localparam logic [5:0] OP_ANDI    = 6'h0C;
    localparam logic [5:0] OP_ORI     = 6'h0D;
    localparam logic [5:0] OP_LUI     = 6'h0F;
    localparam logic [5:0] OP_LB      = 6'h20;
    localparam logic [5:0] OP_LW      = 6'h23;
    localparam logic [5:0] OP_SB      = 6'h28;
    localparam logic [5:0] OP_SW      = 6'h2B;

    // Function codes of the special opcode.
    localparam logic [5:0] FN_SLL  = 6'h00;
    localparam logic [5:0] FN_SRL  = 6'h02;
    localparam logic [5:0] FN_ADDU = 6'h21;
    localparam logic [5:0] FN_SUBU = 6'h23;
    localparam logic [5:0] FN_AND  = 6'h24;
    localparam logic [5:0] FN_OR   = 6'h25;
    localparam logic [5:0] FN_NOR  = 6'h27;
    localparam logic [5:0] FN_SLTU = 6'h2B;

    // Data memory action carried into the memory stage.
    typedef enum logic [2:0] {
        MACT_NONE,
        MACT_LW,
        MACT_LB,
        MACT_SW,
        MACT_SB,
        MACT_PRELOAD,
        MACT_READ
    } mem_act_t;

    // Execute stage result handed to the memory stage.
    typedef struct packed {
        logic        reg_we;
        logic [4:0]  reg_idx;
        logic [31:0] reg_val;
        mem_act_t    act;
        logic        miss;
        addr_t       mem_addr;
        logic [9:0]  word_idx;
        logic [1:0]  lane;
        logic [31:0] store_val;
    } exec_t;

    // One result word.
    typedef struct packed {
        logic        reg_written;
        logic [4:0]  reg_index;
        logic [31:0] reg_value;
        logic        mem_written;
        logic [9:0]  mem_word_index;
        logic [31:0] mem_word_after;
        logic        out_of_range;
        logic [31:0] read_word;
    } result_t;

    // Register file write request.
    typedef struct packed {
        logic        we;
        logic [4:0]  idx;
        logic [31:0] data;
    } rf_wr_t;

    // Data memory write request.
    typedef struct packed {
        logic        we;
        addr_t       addr;
        logic [31:0] data;
    } dm_wr_t;

endpackage

// ----- src/mips_subset_execute_unit.sv -----
// MIPS subset execute unit. Input words arrive on in_valid/in_stall with the
// fields kind, instruction, word_index and word_value; each accepted word
// gives exactly one result word on out_valid/out_stall. The data_base
// register is written through cfg_we/cfg_data; the user must do so only
// while the unit is idle, not enforced by the unit. Pipeline: register file
// read, execute (ALU and address), data memory access with writeback, then
// the output register. One word per cycle is taken unless stalled. ALU
// results are forwarded to the next instruction; an instruction reading
// the destination of the load just ahead of it waits in the execute stage
// while that load is in the memory stage, since the loaded word only leaves
// the data memory read port there. After reset all registers read as zero
// and the data memory is swept to zero over all DATA_WORDS (1024) words,
// one word per cycle; in_stall is high during the sweep while configuration
// writes are still taken. When out_stall is high the result word holds; the
// stages behind it keep taking input until they fill, then in_stall rises.
module mips_subset_execute_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  kind,
    input  logic [31:0] instruction,
    input  logic [9:0]  word_index,
    input  logic [31:0] word_value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        reg_written,
    output logic [4:0]  reg_index,
    output logic [31:0] reg_value,
    output logic        mem_written,
    output logic [9:0]  mem_word_index,
    output logic [31:0] mem_word_after,
    output logic        out_of_range,
    output logic [31:0] read_word
);

    logic [31:0]        data_base_reg;

    logic               s1_valid_reg;
    logic               s1_valid_next;
    logic [1:0]         s1_kind_reg;
    logic [31:0]        s1_instr_reg;
    logic [9:0]         s1_widx_reg;
    logic [31:0]        s1_wval_reg;

    logic               s2_valid_reg;
    logic               s2_valid_next;
    mseu_pkg::exec_t    s2_reg;

    logic               out_valid_reg;
    logic               out_valid_next;
    mseu_pkg::result_t  out_reg;

    logic [4:0]         s1_rs;
    logic [4:0]         s1_rt;
    logic [4:0]         rf_raddr_a;
    logic [4:0]         rf_raddr_b;
    logic [31:0]        rf_rdata_a;
    logic [31:0]        rf_rdata_b;
    logic [31:0]        rs_fwd;
    logic [31:0]        rt_fwd;
    mseu_pkg::exec_t    ex;
    mseu_pkg::addr_t    dm_raddr;
    logic [31:0]        dm_rdata;
    logic               dm_busy;
    mseu_pkg::result_t  res;
    mseu_pkg::rf_wr_t   rf_wr;
    mseu_pkg::dm_wr_t   dm_wr;
    logic               s2_load;
    logic               hazard;
    logic               adv1;
    logic               adv2;
    logic               s1_hold;
    logic               accept;

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_base_reg <= 32'h1000_0000;
        end
        else if (cfg_we)
        begin
            data_base_reg <= cfg_data;
        end
    end

    // Stage flow: a load in the memory stage blocks a dependent instruction.
    assign s1_rs   = s1_instr_reg[25:21];
    assign s1_rt   = s1_instr_reg[20:16];
    assign s2_load = s2_valid_reg && s2_reg.reg_idx != 5'd0
                     && (s2_reg.act == mseu_pkg::MACT_LW || s2_reg.act == mseu_pkg::MACT_LB);
    assign hazard  = s2_load && (s2_reg.reg_idx == s1_rs || s2_reg.reg_idx == s1_rt);
    assign adv2    = s2_valid_reg && (!out_valid_reg || !out_stall);
    assign adv1    = s1_valid_reg && !hazard && (!s2_valid_reg || adv2);
    assign s1_hold = s1_valid_reg && !adv1;
    assign in_stall = dm_busy || s1_hold;
    assign accept  = in_valid && !in_stall;

    // Register file reads for the word that sits in the execute stage next cycle.
    assign rf_raddr_a = s1_hold ? s1_rs : instruction[25:21];
    assign rf_raddr_b = s1_hold ? s1_rt : instruction[20:16];

    mseu_regfile u_regfile (
        .clk     (clk),
        .rst_n   (rst_n),
        .raddr_a (rf_raddr_a),
        .raddr_b (rf_raddr_b),
        .rdata_a (rf_rdata_a),
        .rdata_b (rf_rdata_b),
        .wr      (rf_wr)
    );

    // Forward ALU results that are still in the memory stage.
    assign rs_fwd = (s2_valid_reg && s2_reg.reg_we && s2_reg.reg_idx == s1_rs)
                    ? s2_reg.reg_val : rf_rdata_a;
    assign rt_fwd = (s2_valid_reg && s2_reg.reg_we && s2_reg.reg_idx == s1_rt)
                    ? s2_reg.reg_val : rf_rdata_b;

    mseu_exec u_exec (
        .kind        (s1_kind_reg),
        .instruction (s1_instr_reg),
        .word_index  (s1_widx_reg),
        .word_value  (s1_wval_reg),
        .rs_val      (rs_fwd),
        .rt_val      (rt_fwd),
        .data_base   (data_base_reg),
        .ex          (ex)
    );

    // Data memory read for the word that sits in the memory stage next cycle.
    assign dm_raddr = (s2_valid_reg && !adv2) ? s2_reg.mem_addr : ex.mem_addr;

    mseu_dmem u_dmem (
        .clk   (clk),
        .rst_n (rst_n),
        .raddr (dm_raddr),
        .rdata (dm_rdata),
        .wr    (dm_wr),
        .busy  (dm_busy)
    );

    mseu_wb u_wb (
        .s2        (s2_reg),
        .mem_rdata (dm_rdata),
        .commit    (adv2),
        .res       (res),
        .rf_wr     (rf_wr),
        .dm_wr     (dm_wr)
    );

    // Valid flags of the stages and the output register.
    always_comb
    begin
        s1_valid_next  = accept ? 1'b1 : (adv1 ? 1'b0 : s1_valid_reg);
        s2_valid_next  = adv1 ? 1'b1 : (adv2 ? 1'b0 : s2_valid_reg);
        out_valid_next = adv2 ? 1'b1 : ((out_valid_reg && !out_stall) ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Stage payloads.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_kind_reg  <= kind;
            s1_instr_reg <= instruction;
            s1_widx_reg  <= word_index;
            s1_wval_reg  <= word_value;
        end
        if (adv1)
        begin
            s2_reg <= ex;
        end
        if (adv2)
        begin
            out_reg <= res;
        end
    end

    // Output word.
    assign out_valid      = out_valid_reg;
    assign reg_written    = out_reg.reg_written;
    assign reg_index      = out_reg.reg_index;
    assign reg_value      = out_reg.reg_value;
    assign mem_written    = out_reg.mem_written;
    assign mem_word_index = out_reg.mem_word_index;
    assign mem_word_after = out_reg.mem_word_after;
    assign out_of_range   = out_reg.out_of_range;
    assign read_word      = out_reg.read_word;

`ifndef NO_ASSERTIONS
    // Register zero is never written.
    a_no_r0_write: assert property (@(posedge clk) disable iff (!rst_n)
        rf_wr.we |-> rf_wr.idx != 5'd0)
        else $error("register file write to register zero");

    // Nothing is in flight while the data memory is being cleared.
    a_idle_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        dm_busy |-> !s1_valid_reg && !s2_valid_reg && !out_valid_reg)
        else $error("word in flight during data memory sweep");

    // A held execute stage keeps its word.
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_hold |=> s1_valid_reg && $stable(s1_instr_reg) && $stable(s1_kind_reg))
        else $error("execute stage word lost while held");

    // Loads are never forwarded from the memory stage as ALU results.
    a_load_no_fwd: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && (s2_reg.act == mseu_pkg::MACT_LW
                          || s2_reg.act == mseu_pkg::MACT_LB)) |-> !s2_reg.reg_we)
        else $error("load marked as forwardable ALU result");
`endif

endmodule

// ----- src/mseu_regfile.sv -----
// 32-entry register file with two synchronous read ports and one write port.
module mseu_regfile (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [4:0]           raddr_a,
    input  logic [4:0]           raddr_b,
    output logic [31:0]          rdata_a,
    output logic [31:0]          rdata_b,
    input  mseu_pkg::rf_wr_t     wr
);

    logic [31:0] mem [32];
    logic [31:0] valid_reg;
    logic [31:0] rdata_a_reg;
    logic [31:0] rdata_b_reg;

    // An entry reads as zero until it has been written once.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr.we)
        begin
            valid_reg[wr.idx] <= 1'b1;
        end
    end

    // Array write and registered reads; a same-edge write is passed through.
    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            mem[wr.idx] <= wr.data;
        end
        if (wr.we && wr.idx == raddr_a)
        begin
            rdata_a_reg <= wr.data;
        end
        else
        begin
            rdata_a_reg <= valid_reg[raddr_a] ? mem[raddr_a] : 32'd0;
        end
        if (wr.we && wr.idx == raddr_b)
        begin
            rdata_b_reg <= wr.data;
        end
        else
        begin
            rdata_b_reg <= valid_reg[raddr_b] ? mem[raddr_b] : 32'd0;
        end
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

// ----- src/mseu_dmem.sv -----
// Word-wide data memory with one synchronous read port, one write port and
// a clearing sweep after reset.
module mseu_dmem (
    input  logic                 clk,
    input  logic                 rst_n,
    input  mseu_pkg::addr_t      raddr,
    output logic [31:0]          rdata,
    input  mseu_pkg::dm_wr_t     wr,
    output logic                 busy
);

    logic [31:0]     mem [mseu_pkg::DATA_WORDS];
    logic [31:0]     rdata_reg;
    logic            clr_active_reg;
    logic            clr_active_next;
    mseu_pkg::addr_t clr_cnt_reg;
    mseu_pkg::addr_t clr_cnt_next;
    logic            we_eff;
    mseu_pkg::addr_t waddr_eff;
    logic [31:0]     wdata_eff;

    // The sweep zeroes one word per cycle and ends at the last word.
    always_comb
    begin
        clr_active_next = clr_active_reg;
        clr_cnt_next    = clr_cnt_reg;
        if (clr_active_reg)
        begin
            clr_cnt_next = clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == mseu_pkg::addr_t'(mseu_pkg::DATA_WORDS - 1))
            begin
                clr_active_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_cnt_reg    <= '0;
        end
        else
        begin
            clr_active_reg <= clr_active_next;
            clr_cnt_reg    <= clr_cnt_next;
        end
    end

    // The sweep owns the write port while it runs.
    assign we_eff    = clr_active_reg || wr.we;
    assign waddr_eff = clr_active_reg ? clr_cnt_reg : wr.addr;
    assign wdata_eff = clr_active_reg ? 32'd0 : wr.data;

    // Array write and registered read; a same-edge write is passed through.
    always_ff @(posedge clk)
    begin
        if (we_eff)
        begin
            mem[waddr_eff] <= wdata_eff;
        end
        if (we_eff && waddr_eff == raddr)
        begin
            rdata_reg <= wdata_eff;
        end
        else
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
    assign busy  = clr_active_reg;

endmodule

// ----- src/mseu_exec.sv -----
// Execute stage: decode, integer ALU, effective address and range checks.
module mseu_exec (
    input  logic [1:0]           kind,
    input  logic [31:0]          instruction,
    input  logic [9:0]           word_index,
    input  logic [31:0]          word_value,
    input  logic [31:0]          rs_val,
    input  logic [31:0]          rt_val,
    input  logic [31:0]          data_base,
    output mseu_pkg::exec_t      ex
);

    logic [5:0]         opcode;
    logic [5:0]         funct;
    logic [4:0]         rd;
    logic [4:0]         rt;
    logic [4:0]         shamt;
    logic [15:0]        imm16;
    logic [31:0]        imm_se;
    logic [31:0]        imm_ze;
    logic [31:0]        offset;
    logic               word_in_range;
    logic               widx_in_range;
    logic               alu_ok;
    logic [31:0]        alu_r;
    logic [4:0]         alu_dst;
    logic               is_mem;
    mseu_pkg::mem_act_t mem_act;

    assign opcode = instruction[31:26];
    assign funct  = instruction[5:0];
    assign rd     = instruction[15:11];
    assign rt     = instruction[20:16];
    assign shamt  = instruction[10:6];
    assign imm16  = instruction[15:0];
    assign imm_se = {{16{imm16[15]}}, imm16};
    assign imm_ze = {16'd0, imm16};

    // Byte offset into data memory, wrapping modulo 2^32.
    assign offset        = rs_val + imm_se - data_base;
    assign word_in_range = offset[31:2] < mseu_pkg::WORD_LIMIT;
    assign widx_in_range = 17'(word_index) < mseu_pkg::WIDX_LIMIT;

    // Decode and ALU.
    always_comb
    begin
        alu_ok  = 1'b0;
        alu_r   = 32'd0;
        alu_dst = rt;
        is_mem  = 1'b0;
        mem_act = mseu_pkg::MACT_NONE;
        if (opcode == mseu_pkg::OP_SPECIAL)
        begin
            alu_dst = rd;
            alu_ok  = 1'b1;
            unique case (funct)
                mseu_pkg::FN_ADDU: alu_r = rs_val + rt_val;
                mseu_pkg::FN_SUBU: alu_r = rs_val - rt_val;
                mseu_pkg::FN_AND:  alu_r = rs_val & rt_val;
                mseu_pkg::FN_OR:   alu_r = rs_val | rt_val;
                mseu_pkg::FN_NOR:  alu_r = ~(rs_val | rt_val);
                mseu_pkg::FN_SLTU: alu_r = {31'd0, rs_val < rt_val};
                mseu_pkg::FN_SLL:  alu_r = rt_val << shamt;
                mseu_pkg::FN_SRL:  alu_r = rt_val >> shamt;
                default:           alu_ok = 1'b0;
            endcase
        end
        else
        begin
            unique case (opcode)
                mseu_pkg::OP_ADDIU:
                begin
                    alu_ok = 1'b1;
                    alu_r  = rs_val + imm_se;
                end
                mseu_pkg::OP_ANDI:
                begin
                    alu_ok = 1'b1;
                    alu_r  = rs_val & imm_ze;
                end
                mseu_pkg::OP_ORI:
                begin
                    alu_ok = 1'b1;
                    alu_r  = rs_val | imm_ze;
                end
                mseu_pkg::OP_LUI:
                begin
                    alu_ok = 1'b1;
                    alu_r  = {imm16, 16'd0};
                end
                mseu_pkg::OP_SLTIU:
                begin
                    alu_ok = 1'b1;
                    alu_r  = {31'd0, rs_val < imm_se};
                end
                mseu_pkg::OP_LW:
                begin
                    is_mem  = 1'b1;
                    mem_act = mseu_pkg::MACT_LW;
                end
                mseu_pkg::OP_LB:
                begin
                    is_mem  = 1'b1;
                    mem_act = mseu_pkg::MACT_LB;
                end
                mseu_pkg::OP_SW:
                begin
                    is_mem  = 1'b1;
                    mem_act = mseu_pkg::MACT_SW;
                end
                mseu_pkg::OP_SB:
                begin
                    is_mem  = 1'b1;
                    mem_act = mseu_pkg::MACT_SB;
                end
                default:
                begin
                    alu_ok = 1'b0;
                end
            endcase
        end
    end

    // Assemble the stage result for the word kind at hand.
    always_comb
    begin
        ex     = '0;
        ex.act = mseu_pkg::MACT_NONE;
        unique case (kind)
            mseu_pkg::KIND_EXEC:
            begin
                if (alu_ok && alu_dst != 5'd0)
                begin
                    ex.reg_we  = 1'b1;
                    ex.reg_idx = alu_dst;
                    ex.reg_val = alu_r;
                end
                if (is_mem)
                begin
                    if (word_in_range)
                    begin
                        ex.act       = mem_act;
                        ex.mem_addr  = offset[mseu_pkg::ADDR_W+1:2];
                        ex.word_idx  = offset[11:2];
                        ex.lane      = offset[1:0];
                        ex.reg_idx   = rt;
                        ex.store_val = rt_val;
                    end
                    else
                    begin
                        ex.miss = 1'b1;
                    end
                end
            end
            mseu_pkg::KIND_PRELOAD:
            begin
                if (widx_in_range)
                begin
                    ex.act       = mseu_pkg::MACT_PRELOAD;
                    ex.mem_addr  = mseu_pkg::addr_t'(word_index);
                    ex.store_val = word_value;
                end
                else
                begin
                    ex.miss = 1'b1;
                end
            end
            mseu_pkg::KIND_READ:
            begin
                if (widx_in_range)
                begin
                    ex.act      = mseu_pkg::MACT_READ;
                    ex.mem_addr = mseu_pkg::addr_t'(word_index);
                end
                else
                begin
                    ex.miss = 1'b1;
                end
            end
            default:
            begin
                ex.miss = 1'b0;
            end
        endcase
    end

endmodule

// ----- src/mseu_wb.sv -----
// Memory stage: load extraction, store merge, result assembly and the
// write requests for the register file and data memory.
module mseu_wb (
    input  mseu_pkg::exec_t      s2,
    input  logic [31:0]          mem_rdata,
    input  logic                 commit,
    output mseu_pkg::result_t    res,
    output mseu_pkg::rf_wr_t     rf_wr,
    output mseu_pkg::dm_wr_t     dm_wr
);

    logic [7:0]  lane_byte;
    logic [31:0] merged;

    // Big-endian byte lanes: lane zero is bits 31 to 24.
    always_comb
    begin
        unique case (s2.lane)
            2'd0:
            begin
                lane_byte = mem_rdata[31:24];
                merged    = {s2.store_val[7:0], mem_rdata[23:0]};
            end
            2'd1:
            begin
                lane_byte = mem_rdata[23:16];
                merged    = {mem_rdata[31:24], s2.store_val[7:0], mem_rdata[15:0]};
            end
            2'd2:
            begin
                lane_byte = mem_rdata[15:8];
                merged    = {mem_rdata[31:16], s2.store_val[7:0], mem_rdata[7:0]};
            end
            2'd3:
            begin
                lane_byte = mem_rdata[7:0];
                merged    = {mem_rdata[31:8], s2.store_val[7:0]};
            end
        endcase
    end

    // Result word and write requests.
    always_comb
    begin
        res              = '0;
        dm_wr            = '0;
        dm_wr.addr       = s2.mem_addr;
        res.out_of_range = s2.miss;
        if (s2.reg_we)
        begin
            res.reg_written = 1'b1;
            res.reg_index   = s2.reg_idx;
            res.reg_value   = s2.reg_val;
        end
        unique case (s2.act)
            mseu_pkg::MACT_NONE:
            begin
                dm_wr.we = 1'b0;
            end
            mseu_pkg::MACT_LW:
            begin
                if (s2.reg_idx != 5'd0)
                begin
                    res.reg_written = 1'b1;
                    res.reg_index   = s2.reg_idx;
                    res.reg_value   = mem_rdata;
                end
            end
            mseu_pkg::MACT_LB:
            begin
                if (s2.reg_idx != 5'd0)
                begin
                    res.reg_written = 1'b1;
                    res.reg_index   = s2.reg_idx;
                    res.reg_value   = {{24{lane_byte[7]}}, lane_byte};
                end
            end
            mseu_pkg::MACT_SW:
            begin
                res.mem_written    = 1'b1;
                res.mem_word_index = s2.word_idx;
                res.mem_word_after = s2.store_val;
                dm_wr.we           = commit;
                dm_wr.data         = s2.store_val;
            end
            mseu_pkg::MACT_SB:
            begin
                res.mem_written    = 1'b1;
                res.mem_word_index = s2.word_idx;
                res.mem_word_after = merged;
                dm_wr.we           = commit;
                dm_wr.data         = merged;
            end
            mseu_pkg::MACT_PRELOAD:
            begin
                dm_wr.we   = commit;
                dm_wr.data = s2.store_val;
            end
            mseu_pkg::MACT_READ:
            begin
                res.read_word = mem_rdata;
            end
            default:
            begin
                dm_wr.we = 1'b0;
            end
        endcase
        rf_wr.we   = commit && res.reg_written;
        rf_wr.idx  = res.reg_index;
        rf_wr.data = res.reg_value;
    end

endmodule

// ----- tb/tb_mips_subset_execute_unit.sv -----
module tb_mips_subset_execute_unit;

    import mseu_pkg::*;

    localparam int QUIET_LIMIT = 5000;
    localparam int LONG_HOLD   = 64;
    localparam int PHASES      = 5;
    localparam int RANDOM_PER_PHASE = 340;

    // Reference behavior of the unit: register file, data memory and data_base,
    // plus the queue of result words still owed by the unit.
    class retire_scoreboard;
        logic [31:0] gpr [32];
        logic [31:0] dmem [DATA_WORDS];
        logic [31:0] data_base;
        result_t     owed_results [$];
        int          errors;

        function new();
            foreach (gpr[i]) gpr[i] = '0;
            foreach (dmem[i]) dmem[i] = '0;
            data_base = 32'h1000_0000;
            errors = 0;
        endfunction

        function int pending();
            return owed_results.size();
        endfunction

        // Work out the result word of one accepted word and update the state.
        function result_t execute_word(logic [1:0] k, logic [31:0] ins, logic [9:0] idx,
                                       logic [31:0] val);
            result_t     r;
            logic [5:0]  op;
            logic [31:0] rs_v, rt_v, se, offs, w, b;
            logic [4:0]  rt_n;
            logic [29:0] word;
            logic        do_wr;
            logic [4:0]  wr_idx;
            logic [31:0] wr_val;
            int          sh8;
            r = '0;
            do_wr = 1'b0;
            wr_idx = '0;
            wr_val = '0;
            op = ins[31:26];
            rs_v = gpr[ins[25:21]];
            rt_n = ins[20:16];
            rt_v = gpr[rt_n];
            se = {{16{ins[15]}}, ins[15:0]};
            if (k == KIND_EXEC && op == OP_SPECIAL)
            begin
                do_wr = 1'b1;
                wr_idx = ins[15:11];
                case (ins[5:0])
                    FN_ADDU: wr_val = rs_v + rt_v;
                    FN_SUBU: wr_val = rs_v - rt_v;
                    FN_AND:  wr_val = rs_v & rt_v;
                    FN_OR:   wr_val = rs_v | rt_v;
                    FN_NOR:  wr_val = ~(rs_v | rt_v);
                    FN_SLTU: wr_val = (rs_v < rt_v) ? 32'd1 : 32'd0;
                    FN_SLL:  wr_val = rt_v << ins[10:6];
                    FN_SRL:  wr_val = rt_v >> ins[10:6];
                    default: do_wr = 1'b0;
                endcase
            end
            else if (k == KIND_EXEC)
            begin
                wr_idx = rt_n;
                case (op)
                    OP_ADDIU: begin do_wr = 1'b1; wr_val = rs_v + se; end
                    OP_ANDI:  begin do_wr = 1'b1; wr_val = rs_v & {16'h0, ins[15:0]}; end
                    OP_ORI:   begin do_wr = 1'b1; wr_val = rs_v | {16'h0, ins[15:0]}; end
                    OP_LUI:   begin do_wr = 1'b1; wr_val = {ins[15:0], 16'h0}; end
                    OP_SLTIU: begin do_wr = 1'b1; wr_val = (rs_v < se) ? 32'd1 : 32'd0; end
                    OP_LW, OP_LB, OP_SW, OP_SB:
                    begin
                        // Offset into data memory wraps modulo 2^32.
                        offs = rs_v + se - data_base;
                        word = offs[31:2];
                        sh8 = (3 - offs[1:0]) * 8;
                        if (word >= DATA_WORDS)
                        begin
                            r.out_of_range = 1'b1;
                        end
                        else
                        begin
                            w = dmem[word];
                            if (op == OP_LW)
                            begin
                                do_wr = 1'b1;
                                wr_val = w;
                            end
                            else if (op == OP_LB)
                            begin
                                b = (w >> sh8) & 32'hFF;
                                do_wr = 1'b1;
                                wr_val = {{24{b[7]}}, b[7:0]};
                            end
                            else
                            begin
                                if (op == OP_SW)
                                    w = rt_v;
                                else
                                    w = (w & ~(32'hFF << sh8)) | ({24'h0, rt_v[7:0]} << sh8);
                                dmem[word] = w;
                                r.mem_written = 1'b1;
                                r.mem_word_index = word[9:0];
                                r.mem_word_after = w;
                            end
                        end
                    end
                    default: ;
                endcase
            end
            else if (k == KIND_PRELOAD)
            begin
                if (idx < DATA_WORDS)
                    dmem[idx] = val;
                else
                    r.out_of_range = 1'b1;
            end
            else if (k == KIND_READ)
            begin
                if (idx < DATA_WORDS)
                    r.read_word = dmem[idx];
                else
                    r.out_of_range = 1'b1;
            end
            // Writes to register zero are dropped without a report.
            if (do_wr && wr_idx != 5'd0)
            begin
                gpr[wr_idx] = wr_val;
                r.reg_written = 1'b1;
                r.reg_index = wr_idx;
                r.reg_value = wr_val;
            end
            gpr[0] = '0;
            return r;
        endfunction

        function void note_accepted(logic [1:0] k, logic [31:0] ins, logic [9:0] idx,
                                    logic [31:0] val);
            owed_results = {owed_results, execute_word(k, ins, idx, val)};
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                errors++;
                $display("%0t: %s expected %h actual %h", $time, name, want, got);
            end
        endfunction

        // Match one result word against the oldest owed result.
        function void check_retired(result_t got);
            result_t want;
            if (owed_results.size() == 0)
            begin
                errors++;
                $display("%0t: result word expected none actual %h", $time, got);
                return;
            end
            want = owed_results.pop_front();
            compare_field("reg_written", want.reg_written, got.reg_written);
            compare_field("reg_index", want.reg_index, got.reg_index);
            compare_field("reg_value", want.reg_value, got.reg_value);
            compare_field("mem_written", want.mem_written, got.mem_written);
            compare_field("mem_word_index", want.mem_word_index, got.mem_word_index);
            compare_field("mem_word_after", want.mem_word_after, got.mem_word_after);
            compare_field("out_of_range", want.out_of_range, got.out_of_range);
            compare_field("read_word", want.read_word, got.read_word);
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [31:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  kind = '0;
    logic [31:0] instruction = '0;
    logic [9:0]  word_index = '0;
    logic [31:0] word_value = '0;
    logic        out_valid;
    logic        out_stall = 1'b1;
    logic        reg_written;
    logic [4:0]  reg_index;
    logic [31:0] reg_value;
    logic        mem_written;
    logic [9:0]  mem_word_index;
    logic [31:0] mem_word_after;
    logic        out_of_range;
    logic [31:0] read_word;

    retire_scoreboard tracker = new();

    bit idle_en = 1'b1;
    bit long_hold = 1'b0;
    int out_wait = 0;
    int quiet = 0;

    logic [5:0] fn_list [8] = '{FN_ADDU, FN_SUBU, FN_AND, FN_OR, FN_NOR, FN_SLTU,
                                FN_SLL, FN_SRL};
    logic [5:0] ialu_ops [5] = '{OP_ADDIU, OP_SLTIU, OP_ANDI, OP_ORI, OP_LUI};
    logic [5:0] mem_ops [4] = '{OP_LW, OP_LB, OP_SW, OP_SB};

    mips_subset_execute_unit uut (.*);

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic [31:0] rtype(logic [5:0] fn, logic [4:0] rs, logic [4:0] rt,
                                          logic [4:0] rd, logic [4:0] sh);
        return {OP_SPECIAL, rs, rt, rd, sh, fn};
    endfunction

    function automatic logic [31:0] itype(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
                                          logic [15:0] imm);
        return {op, rs, rt, imm};
    endfunction

    // Offer one word and hold it until taken; entered and left at a falling edge.
    task automatic send_word(logic [1:0] k, logic [31:0] ins, logic [9:0] idx,
                             logic [31:0] val);
        int gap;
        gap = idle_en ? $urandom_range(0, 3) : 0;
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        kind = k;
        instruction = ins;
        word_index = idx;
        word_value = val;
        in_valid = 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        tracker.note_accepted(k, ins, idx, val);
        @(negedge clk);
    endtask

    task automatic run_exec(logic [31:0] ins);
        send_word(KIND_EXEC, ins, 10'($urandom), $urandom);
    endtask

    // Stop offering and let every owed result come back.
    task automatic wait_results();
        in_valid = 1'b0;
        while (tracker.pending() > 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    // Result side: random stalls per word, plus one long hold on request.
    always
    begin
        @(negedge clk);
        if (long_hold)
        begin
            out_stall = 1'b1;
            repeat (LONG_HOLD) @(negedge clk);
            long_hold = 1'b0;
        end
        else if (out_wait > 0)
        begin
            out_stall = 1'b1;
            out_wait--;
        end
        else
        begin
            out_stall = 1'b0;
        end
    end

    always @(posedge clk)
    begin
        result_t got;
        if (out_valid && !out_stall)
        begin
            got.reg_written = reg_written;
            got.reg_index = reg_index;
            got.reg_value = reg_value;
            got.mem_written = mem_written;
            got.mem_word_index = mem_word_index;
            got.mem_word_after = mem_word_after;
            got.out_of_range = out_of_range;
            got.read_word = read_word;
            tracker.check_retired(got);
            out_wait = idle_en ? $urandom_range(0, 3) : 0;
        end
    end

    // Watchdog on cycles in which neither channel moves a word.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            quiet = 0;
        end
        else
        begin
            quiet++;
            if (quiet == QUIET_LIMIT)
            begin
                $display("tb_mips_subset_execute_unit: errors");
                $finish;
            end
        end
    end

    initial
    begin
        int          p, n, sel;
        logic [31:0] addr, offs, hi;
        logic [4:0]  rs, rt;
        logic [5:0]  op;
        bit          mem_pend;
        logic [31:0] bases [PHASES];
        bases = '{32'h1000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_F800, $urandom};
        mem_pend = 1'b0;
        rs = '0;
        rt = '0;
        op = OP_LW;
        addr = '0;

        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        for (p = 0; p < PHASES; p++)
        begin
            wait_results();
            // data_base is written while the unit is idle (or still clearing).
            cfg_we = 1'b1;
            cfg_data = bases[p];
            @(negedge clk);
            cfg_we = 1'b0;
            tracker.data_base = bases[p];
            mem_pend = 1'b0;

            if (p == 0)
            begin
                // Immediates: lui, zero-extended ori/andi, sign-extended addiu.
                run_exec(itype(OP_LUI, 5'd0, 5'd1, 16'h1000));
                run_exec(itype(OP_ORI, 5'd0, 5'd2, 16'hFFFF));
                run_exec(itype(OP_ADDIU, 5'd0, 5'd3, 16'hFFFF));
                run_exec(itype(OP_ANDI, 5'd3, 5'd4, 16'h8001));
                // Register-register operations, wrap-around add and subtract.
                run_exec(rtype(FN_ADDU, 5'd3, 5'd3, 5'd5, 5'd0));
                run_exec(rtype(FN_SUBU, 5'd0, 5'd2, 5'd6, 5'd0));
                run_exec(rtype(FN_AND, 5'd3, 5'd2, 5'd7, 5'd0));
                run_exec(rtype(FN_OR, 5'd6, 5'd2, 5'd8, 5'd0));
                run_exec(rtype(FN_NOR, 5'd0, 5'd0, 5'd9, 5'd0));
                // Unsigned compares, including a sign-extended negative immediate.
                run_exec(rtype(FN_SLTU, 5'd2, 5'd3, 5'd10, 5'd0));
                run_exec(itype(OP_SLTIU, 5'd2, 5'd11, 16'h8000));
                // Shifts by the full amount; srl must shift in zeros.
                run_exec(rtype(FN_SLL, 5'd0, 5'd3, 5'd12, 5'd31));
                run_exec(rtype(FN_SRL, 5'd0, 5'd3, 5'd13, 5'd31));
                // A write to register zero is dropped.
                run_exec(itype(OP_ADDIU, 5'd3, 5'd0, 16'h0005));
                send_word(KIND_PRELOAD, '0, 10'd1023, 32'h80FF_7F01);
                send_word(KIND_PRELOAD, '0, 10'd0, 32'h1234_5678);
                // Last word of memory; lb sign-extends lane 0 and reads lane 3.
                run_exec(itype(OP_LW, 5'd1, 5'd14, 16'h0FFC));
                run_exec(itype(OP_LB, 5'd1, 5'd15, 16'h0FFC));
                run_exec(itype(OP_LB, 5'd1, 5'd16, 16'h0FFF));
                // Misaligned sw uses the containing word; sb into lane 2.
                run_exec(itype(OP_SW, 5'd1, 5'd3, 16'h0001));
                run_exec(itype(OP_SB, 5'd1, 5'd13, 16'h0002));
                // Negative offset below memory and one word past its end.
                run_exec(itype(OP_LW, 5'd1, 5'd17, 16'hFFFC));
                run_exec(itype(OP_SW, 5'd1, 5'd3, 16'h1000));
                send_word(KIND_READ, '0, 10'd0, '0);
                // Unknown opcode, unknown function code, unused kind.
                run_exec(itype(6'h3F, 5'd3, 5'd18, 16'h1234));
                run_exec(rtype(6'h01, 5'd3, 5'd3, 5'd19, 5'd0));
                send_word(2'd3, $urandom, 10'($urandom), $urandom);
            end

            for (n = 0; n < RANDOM_PER_PHASE; n++)
            begin
                if (n % 100 == 0)
                    idle_en = ($urandom_range(0, 3) != 0);
                if (p == 2 && n == 50)
                    long_hold = 1'b1;

                if (mem_pend)
                begin
                    // The pointer register now lies within reach of the offset.
                    offs = addr - tracker.gpr[rs];
                    run_exec(itype(op, rs, rt, offs[15:0]));
                    mem_pend = 1'b0;
                    continue;
                end

                sel = $urandom_range(0, 99);
                if (sel < 8)
                begin
                    send_word(2'($urandom), $urandom, 10'($urandom), $urandom);
                end
                else if (sel < 20)
                begin
                    send_word(KIND_PRELOAD, $urandom, 10'($urandom), $urandom);
                end
                else if (sel < 28)
                begin
                    send_word(KIND_READ, $urandom, 10'($urandom), $urandom);
                end
                else if (sel < 50)
                begin
                    run_exec(rtype(fn_list[$urandom_range(0, 7)], 5'($urandom),
                                   5'($urandom), 5'($urandom), 5'($urandom)));
                end
                else if (sel < 70)
                begin
                    run_exec(itype(ialu_ops[$urandom_range(0, 4)], 5'($urandom),
                                   5'($urandom), 16'($urandom)));
                end
                else
                begin
                    // Load or store aimed mostly inside memory, now and then anywhere.
                    op = mem_ops[$urandom_range(0, 3)];
                    rs = 5'($urandom);
                    rt = 5'($urandom);
                    if ($urandom_range(0, 9) == 0)
                        addr = $urandom;
                    else
                        addr = tracker.data_base + $urandom_range(0, 4095);
                    offs = addr - tracker.gpr[rs];
                    if (offs[31:15] == 17'h0 || offs[31:15] == 17'h1FFFF)
                    begin
                        run_exec(itype(op, rs, rt, offs[15:0]));
                    end
                    else
                    begin
                        // Set up a pointer first; the access follows next.
                        if (rs == 5'd0)
                            rs = 5'($urandom_range(1, 31));
                        hi = (addr + 32'h8000) >> 16;
                        run_exec(itype(OP_LUI, 5'd0, rs, hi[15:0]));
                        mem_pend = 1'b1;
                    end
                end
            end
        end

        wait_results();
        repeat (10) @(negedge clk);
        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("tb_mips_subset_execute_unit: clean");
        else
            $display("tb_mips_subset_execute_unit: errors");
        $finish;
    end

endmodule
